// ===== hw/rtl/m68kold_pkg.sv =====
package m68kold_pkg;

    localparam int NUM_ROWS = 81;
    localparam int ROW_W = 7;
    localparam int NUM_GROUPS = 11;
    localparam int GROUP_SIZE = 8;
    localparam int MATCH_W = NUM_GROUPS * GROUP_SIZE;
    localparam logic [ROW_W-1:0] NO_MATCH = ROW_W'(NUM_ROWS);

    typedef enum logic [4:0] {
        KIND_MOVE, KIND_BRA, KIND_ORSR, KIND_IMM, KIND_MOVES, KIND_BIT, KIND_MOVESR,
        KIND_SONE, KIND_ONE, KIND_REG, KIND_EXTW, KIND_EXTL, KIND_MOVEM, KIND_TRAP,
        KIND_ONEWORD, KIND_PLAIN, KIND_MOVEC, KIND_CHK, KIND_DBCC, KIND_SCC,
        KIND_QUICK, KIND_MOVEQ, KIND_OPMODE, KIND_EXTEND, KIND_SHIFT
    } t_kind;

    typedef enum logic [1:0] {
        SIZE_NONE = 2'd0,
        SIZE_BYTE = 2'd1,
        SIZE_WORD = 2'd2,
        SIZE_LONG = 2'd3
    } t_size;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic             recognized;
        logic [1:0]       operand_size;
        logic [2:0]       src_mode;
        logic [2:0]       src_reg;
        logic [2:0]       dst_mode;
        logic [2:0]       dst_reg;
        logic [2:0]       ext_words;
    } t_result;

    localparam logic [15:0] ROW_MASK [NUM_ROWS] = '{
        16'hF000, 16'hF000, 16'hF000,
        16'hF000,
        16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF,
        16'hFF00, 16'hFF00, 16'hFF00,
        16'hFF00, 16'hFF00, 16'hFF00,
        16'hFF00,
        16'hF100, 16'hF800,
        16'hFFC0, 16'hFF00,
        16'hFFC0, 16'hFF00,
        16'hFFC0, 16'hFF00,
        16'hFFC0, 16'hFF00,
        16'hFFC0, 16'hFFF8, 16'hFFC0,
        16'hFFF8, 16'hFFF8, 16'hFB80,
        16'hFFC0, 16'hFF00, 16'hFFF0,
        16'hFFF8, 16'hFFF8, 16'hFFF8,
        16'hFFF8, 16'hFFF8, 16'hFFF8,
        16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFE,
        16'hFFC0, 16'hFFC0,
        16'hF1C0, 16'hF1C0,
        16'hF0F8, 16'hF0C0,
        16'hF100, 16'hF100,
        16'hF000,
        16'hF1C0, 16'hF1C0, 16'hF1F0,
        16'hF000, 16'hF1C0, 16'hF130,
        16'hF000, 16'hF1C0, 16'hF138,
        16'hF100, 16'hF100,
        16'hF1C0, 16'hF1C0,
        16'hF1F8, 16'hF1F8, 16'hF1F8,
        16'hF1F0, 16'hF000,
        16'hF1C0, 16'hF130, 16'hF000,
        16'hF100, 16'hF100
    };

    localparam logic [15:0] ROW_MATCH [NUM_ROWS] = '{
        16'h1000, 16'h2000, 16'h3000,
        16'h6000,
        16'h003C, 16'h007C, 16'h023C,
        16'h027C,
        16'h0000, 16'h0200, 16'h0400,
        16'h0600, 16'h0A00, 16'h0C00,
        16'h0E00,
        16'h0100, 16'h0800,
        16'h40C0, 16'h4000,
        16'h42C0, 16'h4200,
        16'h44C0, 16'h4400,
        16'h46C0, 16'h4600,
        16'h4800, 16'h4840, 16'h4840,
        16'h4880, 16'h48C0, 16'h4880,
        16'h4AC0, 16'h4A00, 16'h4E40,
        16'h4E50, 16'h4880, 16'h48C0,
        16'h4E58, 16'h4E60, 16'h4E68,
        16'h4E70, 16'h4E71, 16'h4E72,
        16'h4E73, 16'h4E74, 16'h4E75,
        16'h4E76, 16'h4E77, 16'h4E7A,
        16'h4E80, 16'h4EC0,
        16'h4180, 16'h41C0,
        16'h50C8, 16'h50C0,
        16'h5000, 16'h5100,
        16'h7000,
        16'h80C0, 16'h81C0, 16'h8100,
        16'h8000, 16'h91C0, 16'h9100,
        16'h9000, 16'hB1C0, 16'hB108,
        16'hB000, 16'hB100,
        16'hC0C0, 16'hC1C0,
        16'hC188, 16'hC148, 16'hC140,
        16'hC100, 16'hC000,
        16'hD1C0, 16'hD100, 16'hD000,
        16'hE000, 16'hE100
    };

    localparam t_kind ROW_KIND [NUM_ROWS] = '{
        KIND_MOVE, KIND_MOVE, KIND_MOVE,
        KIND_BRA,
        KIND_ORSR, KIND_ORSR, KIND_ORSR,
        KIND_ORSR,
        KIND_IMM, KIND_IMM, KIND_IMM,
        KIND_IMM, KIND_IMM, KIND_IMM,
        KIND_MOVES,
        KIND_BIT, KIND_BIT,
        KIND_MOVESR, KIND_SONE,
        KIND_MOVESR, KIND_SONE,
        KIND_MOVESR, KIND_SONE,
        KIND_MOVESR, KIND_SONE,
        KIND_ONE, KIND_REG, KIND_ONE,
        KIND_EXTW, KIND_EXTL, KIND_MOVEM,
        KIND_ONE, KIND_SONE, KIND_TRAP,
        KIND_ONEWORD, KIND_EXTW, KIND_EXTL,
        KIND_REG, KIND_REG, KIND_REG,
        KIND_PLAIN, KIND_PLAIN, KIND_ONEWORD,
        KIND_PLAIN, KIND_ONEWORD, KIND_PLAIN,
        KIND_PLAIN, KIND_PLAIN, KIND_MOVEC,
        KIND_ONE, KIND_ONE,
        KIND_CHK, KIND_CHK,
        KIND_DBCC, KIND_SCC,
        KIND_QUICK, KIND_QUICK,
        KIND_MOVEQ,
        KIND_CHK, KIND_CHK, KIND_EXTEND,
        KIND_OPMODE, KIND_OPMODE, KIND_EXTEND,
        KIND_OPMODE, KIND_OPMODE, KIND_EXTEND,
        KIND_OPMODE, KIND_OPMODE,
        KIND_CHK, KIND_CHK,
        KIND_EXTEND, KIND_EXTEND, KIND_EXTEND,
        KIND_EXTEND, KIND_OPMODE,
        KIND_OPMODE, KIND_EXTEND, KIND_OPMODE,
        KIND_SHIFT, KIND_SHIFT
    };

endpackage

// ===== hw/rtl/m68kold_decode.sv =====
module m68kold_decode
    import m68kold_pkg::*;
(
    input  logic             i_found,
    input  logic [ROW_W-1:0] i_row,
    input  logic [15:0]      i_opcode,
    input  logic [15:0]      i_first_ext,
    output t_result          o_result
);

    function automatic logic [2:0] ea_words(input logic [2:0] mode, input logic [2:0] rg,
                                            input logic [1:0] sz);
        logic [2:0] w;
        w = 3'd0;
        if (mode == 3'd5 || mode == 3'd6) begin
            w = 3'd1;
        end else if (mode == 3'd7) begin
            case (rg)
                3'd0, 3'd2, 3'd3: w = 3'd1;
                3'd1:             w = 3'd2;
                3'd4:             w = (sz == SIZE_LONG) ? 3'd2 : 3'd1;
                default:          w = 3'd0;
            endcase
        end
        return w;
    endfunction

    t_kind      kind;
    logic [2:0] m;
    logic [2:0] r;
    logic [1:0] szf;
    logic [1:0] msz;
    logic       ok;
    logic       ea;
    logic [1:0] size;
    logic [2:0] sm;
    logic [2:0] sr;
    logic [2:0] dm;
    logic [2:0] dr;
    logic [2:0] words;
    logic [2:0] om;

    always_comb begin
        kind  = ROW_KIND[i_row];
        m     = i_opcode[5:3];
        r     = i_opcode[2:0];
        szf   = i_opcode[7:6];
        msz   = (szf == 2'd3) ? SIZE_NONE : szf + 2'd1;
        om    = i_opcode[8:6];
        ok    = i_found;
        ea    = 1'b0;
        size  = SIZE_NONE;
        sm    = 3'd0;
        sr    = 3'd0;
        dm    = 3'd0;
        dr    = 3'd0;
        words = 3'd0;

        if (i_found) begin
            unique case (kind)
                KIND_MOVE: begin
                    size  = (i_opcode[13:12] == 2'd1) ? SIZE_BYTE :
                            (i_opcode[13:12] == 2'd2) ? SIZE_LONG : SIZE_WORD;
                    ea    = 1'b1;
                    dm    = i_opcode[8:6];
                    dr    = i_opcode[11:9];
                    words = ea_words(dm, dr, size);
                end
                KIND_BRA: begin
                    words = (i_opcode[7:0] == 8'd0) ? 3'd1 : 3'd0;
                end
                KIND_ORSR: begin
                    size  = i_opcode[6] ? SIZE_WORD : SIZE_BYTE;
                    words = 3'd1;
                end
                KIND_IMM: begin
                    if (msz == SIZE_NONE) begin
                        ok = 1'b0;
                    end else begin
                        size  = msz;
                        ea    = 1'b1;
                        words = (msz == SIZE_LONG) ? 3'd2 : 3'd1;
                    end
                end
                KIND_MOVES: begin
                    words = 3'd1;
                    if (msz == SIZE_NONE || i_first_ext[10:0] != 11'd0) begin
                        ok = 1'b0;
                    end else begin
                        size = msz;
                        ea   = 1'b1;
                    end
                end
                KIND_BIT: begin
                    ea    = 1'b1;
                    words = i_opcode[8] ? 3'd0 : 3'd1;
                end
                KIND_MOVESR: begin
                    size = SIZE_WORD;
                    ea   = 1'b1;
                end
                KIND_SONE, KIND_QUICK: begin
                    if (msz == SIZE_NONE) begin
                        ok = 1'b0;
                    end else begin
                        size = msz;
                        ea   = 1'b1;
                    end
                end
                KIND_ONE, KIND_CHK: begin
                    ea = 1'b1;
                end
                KIND_EXTW: begin
                    size = SIZE_WORD;
                end
                KIND_EXTL: begin
                    size = SIZE_LONG;
                end
                KIND_MOVEM: begin
                    size  = i_opcode[6] ? SIZE_LONG : SIZE_WORD;
                    ea    = 1'b1;
                    words = 3'd1;
                end
                KIND_ONEWORD: begin
                    words = 3'd1;
                end
                KIND_MOVEC: begin
                    words = 3'd1;
                    if (i_first_ext[10:1] != 10'd0) begin
                        ok = 1'b0;
                    end
                end
                KIND_DBCC: begin
                    sr    = r;
                    words = 3'd1;
                end
                KIND_SCC: begin
                    size = SIZE_BYTE;
                    ea   = 1'b1;
                end
                KIND_OPMODE: begin
                    ea = 1'b1;
                    if (om == 3'd0 || om == 3'd4) begin
                        size = SIZE_BYTE;
                    end else if (om == 3'd1 || om == 3'd3 || om == 3'd5) begin
                        size = SIZE_WORD;
                    end else begin
                        size = SIZE_LONG;
                    end
                end
                KIND_EXTEND: begin
                    if (i_opcode[12]) begin
                        if (msz == SIZE_NONE) begin
                            ok = 1'b0;
                        end else begin
                            size = msz;
                        end
                    end
                end
                KIND_SHIFT: begin
                    if (szf == 2'd3) begin
                        ea = 1'b1;
                    end else begin
                        size = msz;
                    end
                end
                default: begin
                end
            endcase

            if (ok && ea) begin
                sm    = m;
                sr    = r;
                words = words + ea_words(m, r, (size == SIZE_NONE) ? SIZE_WORD : size);
            end
            if (!ok) begin
                size = SIZE_NONE;
                sm   = 3'd0;
                sr   = 3'd0;
                dm   = 3'd0;
                dr   = 3'd0;
            end
        end

        o_result.row_index    = i_found ? i_row : NO_MATCH;
        o_result.recognized   = ok;
        o_result.operand_size = size;
        o_result.src_mode     = sm;
        o_result.src_reg      = sr;
        o_result.dst_mode     = dm;
        o_result.dst_reg      = dr;
        o_result.ext_words    = words;
    end

endmodule

// ===== hw/rtl/m68k_opcode_length_decoder.sv =====
// Input transfers pass r_match, r_hit/r_loc, r_row and r_out, the output registers.
// Throughput: one opcode per cycle; each of the four register stages (row match,
// group priority, row select, class decode) advances whenever the next one has room,
// so an output stall first fills empty stages and o_stall rises only when all are full.
// Reset (i_rst_n low, synchronous) empties every stage; payload is not cleared.
module m68k_opcode_length_decoder
    import m68kold_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [15:0]      i_opcode,
    input  logic [15:0]      i_first_ext,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ROW_W-1:0] o_row_index,
    output logic             o_recognized,
    output logic [1:0]       o_operand_size,
    output logic [2:0]       o_src_mode,
    output logic [2:0]       o_src_reg,
    output logic [2:0]       o_dst_mode,
    output logic [2:0]       o_dst_reg,
    output logic [2:0]       o_ext_words
);

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic               adv1;
    logic               adv2;
    logic               adv3;
    logic               adv4;

    logic [MATCH_W-1:0] n_match;
    logic [MATCH_W-1:0] r_match;
    logic [15:0]        r_op1;
    logic [15:0]        r_ext1;

    logic [NUM_GROUPS-1:0] n_hit;
    logic [2:0]            n_loc [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] r_hit;
    logic [2:0]            r_loc [NUM_GROUPS];
    logic [15:0]           r_op2;
    logic [15:0]           r_ext2;

    logic               n_found;
    logic [ROW_W-1:0]   n_row;
    logic               r_found;
    logic [ROW_W-1:0]   r_row;
    logic [15:0]        r_op3;
    logic [15:0]        r_ext3;

    t_result            n_out;
    t_result            r_out;

    assign adv4    = !r_v4 || !i_stall;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        n_match = '0;
        for (int i = 0; i < NUM_ROWS; i++) begin
            n_match[i] = (i_opcode & ROW_MASK[i]) == ROW_MATCH[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_match <= n_match;
            r_op1   <= i_opcode;
            r_ext1  <= i_first_ext;
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_hit[g] = |r_match[g*GROUP_SIZE +: GROUP_SIZE];
            n_loc[g] = 3'd0;
            for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
                if (r_match[g*GROUP_SIZE + j]) n_loc[g] = 3'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_hit  <= n_hit;
            r_loc  <= n_loc;
            r_op2  <= r_op1;
            r_ext2 <= r_ext1;
        end
    end

    always_comb begin
        n_found = |r_hit;
        n_row   = NO_MATCH;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (r_hit[g]) n_row = {4'(g), r_loc[g]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_found <= n_found;
            r_row   <= n_row;
            r_op3   <= r_op2;
            r_ext3  <= r_ext2;
        end
    end

    m68kold_decode u_decode (
        .i_found     (r_found),
        .i_row       (r_row),
        .i_opcode    (r_op3),
        .i_first_ext (r_ext3),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_v4;
    assign o_row_index    = r_out.row_index;
    assign o_recognized   = r_out.recognized;
    assign o_operand_size = r_out.operand_size;
    assign o_src_mode     = r_out.src_mode;
    assign o_src_reg      = r_out.src_reg;
    assign o_dst_mode     = r_out.dst_mode;
    assign o_dst_reg      = r_out.dst_reg;
    assign o_ext_words    = r_out.ext_words;

`ifndef SYNTH
    a_recog_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && o_recognized |-> o_row_index != NO_MATCH)
        else $error("recognized result without a matching row");

    a_nomatch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && o_row_index == NO_MATCH |-> !o_recognized && o_ext_words == 3'd0)
        else $error("unmatched opcode carries a result");

    a_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !o_recognized |-> o_operand_size == SIZE_NONE && o_src_mode == 3'd0 &&
            o_src_reg == 3'd0 && o_dst_mode == 3'd0 && o_dst_reg == 3'd0)
        else $error("bad opcode leaves size or address fields set");

    a_words_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> o_ext_words <= 3'd4)
        else $error("extension word count out of range");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v1)
        else $error("transfer in did not reach the first stage");
`endif

endmodule
